FILE: hw/rtl/cel_pkg.sv
// Package with the widths, constants and shared types of the cross-entropy loss block.
`timescale 1ns / 1ps

package cel_pkg;

    localparam int MAX_CLASSES = 1024;
    localparam int MAX_SAMPLES = 65536;

    localparam int PROB_W  = 16;
    localparam int TW_W    = 17;
    localparam int COL_W   = 10;
    localparam int MEAN_W  = 24;
    localparam int ACC_W   = 48;
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int NUM_W   = ACC_W + 1;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 2;
    localparam int L2_W    = 21;
    localparam int NL_W    = 20;
    localparam int PROD_W  = 53;
    localparam int MUL_W   = 32;
    localparam int LOG_STEPS = 16;
    localparam int STEP_W  = $clog2(LOG_STEPS);

    localparam logic [MUL_W-1:0]  LN2_Q32  = 32'd2977044472;
    localparam logic [TW_W-1:0]   ONE_Q16  = 17'd65536;
    localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};
    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};

    localparam logic [CFGI_W-1:0] CFG_CLIP_LOW  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_CLIP_HIGH = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SPARSE    = 2'd2;

    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [MEAN_W-1:0] quot;
    } t_div_res;

endpackage

FILE: hw/rtl/cross_entropy_loss_mean.sv
// Top level of the batch-mean cross-entropy loss block.
//
// Usage: one input transaction carries one class element (probability,
// target weight, label, column and the sample and batch end flags). The block
// stalls its input while it works on an element: an accept step, a
// normalize step, sixteen squaring steps, then the ln(2) multiply, the
// target weight multiply and the accumulate. The single shared 32x32
// multiplier is reused by the log2 squaring loop and both scalings.
// An element with last_of_batch adds the mean division: an add step and
// the restoring divider (range check, 24 quotient steps and the done
// step); an empty batch skips the divider and an overflowing one leaves
// it after the range check. Then the result moves to the output register.
// The output register holds one result transaction; new elements are taken
// while it waits for the receiver. If the receiver stalls and a second
// result is ready, the block holds that result and its input until the
// output register is free. Reset (synchronous, active low) clears the
// accumulator, sample count and overflow flag, returns the clip bounds to
// their defaults and drops the output valid. Configuration writes take
// effect at once and are meant to be made while the block is idle.
`timescale 1ns / 1ps

module cross_entropy_loss_mean (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_we,
    input  logic [cel_pkg::CFGI_W-1:0]     i_cfg_index,
    input  logic [cel_pkg::CFG_W-1:0]      i_cfg_data,

    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [cel_pkg::PROB_W-1:0]     i_prob,
    input  logic [cel_pkg::TW_W-1:0]       i_target_weight,
    input  logic [cel_pkg::COL_W-1:0]      i_true_label,
    input  logic [cel_pkg::COL_W-1:0]      i_column,
    input  logic                           i_last_of_sample,
    input  logic                           i_last_of_batch,

    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cel_pkg::MEAN_W-1:0]     o_loss_mean,
    output logic                           o_empty_batch,
    output logic                           o_saturated
);
    import cel_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_NORM  = 8'b0000_0010,
        ST_SQR   = 8'b0000_0100,
        ST_LN2   = 8'b0000_1000,
        ST_TERM  = 8'b0001_0000,
        ST_ACC   = 8'b0010_0000,
        ST_FIN   = 8'b0100_0000,
        ST_DWAIT = 8'b1000_0000
    } t_state;

    // Output hand-off is folded into the finish states through r_res_pend.
    t_state              r_state;
    logic [PROB_W-1:0]   r_clip_low;
    logic [PROB_W-1:0]   r_clip_high;
    logic                r_sparse;

    logic [PROB_W-1:0]   r_c;
    logic [TW_W-1:0]     r_y;
    logic                r_los;
    logic                r_lob;
    logic [3:0]          r_e;
    logic [PROB_W-1:0]   r_m;
    logic [PROB_W-1:0]   r_f;
    logic [STEP_W-1:0]   r_step;
    logic [PROD_W-1:0]   r_prod;

    logic [ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf_seen;

    logic                r_res_pend;
    logic [MEAN_W-1:0]   r_res_mean;
    logic                r_res_empty;
    logic                r_res_sat;

    logic                r_out_valid;
    logic [MEAN_W-1:0]   r_out_mean;
    logic                r_out_empty;
    logic                r_out_sat;

    logic                w_in_acc;
    logic                w_out_free;
    logic [PROB_W-1:0]   w_c;
    logic [TW_W-1:0]     w_y;
    logic [3:0]          w_e;
    logic [PROB_W-1:0]   w_m_norm;
    logic [MUL_W-1:0]    w_mul_a;
    logic [MUL_W-1:0]    w_mul_b;
    logic [2*MUL_W-1:0]  w_prod;
    logic [PROB_W:0]     w_sq;
    logic [L2_W-1:0]     w_l2;
    logic [NL_W-1:0]     w_nl;
    logic [PROD_W-16:0]  w_term;
    logic [ACC_W:0]      w_sum;
    logic                w_div_start;
    logic [NUM_W-1:0]    w_div_num;
    t_div_res            w_div;

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE) || r_res_pend;

    // Clip to the bounds; a crossed pair resolves to the lower bound.
    always_comb begin
        w_c = (i_prob < r_clip_high) ? i_prob : r_clip_high;
        if (w_c < r_clip_low) begin
            w_c = r_clip_low;
        end
        if (w_c == '0) begin
            w_c = PROB_W'(1);
        end
        if (r_sparse) begin
            w_y = (i_column == i_true_label) ? ONE_Q16 : '0;
        end else begin
            w_y = i_target_weight;
        end
        if (int'(i_column) >= MAX_CLASSES) begin
            w_y = '0;
        end
    end

    always_comb begin
        w_e = '0;
        for (int i = 0; i < PROB_W; i++) begin
            if (r_c[i]) begin
                w_e = 4'(i);
            end
        end
        w_m_norm = r_c << (4'd15 - w_e);
    end

    // Shared multiplier: squaring, ln(2) scaling and target weighting.
    always_comb begin
        case (r_state)
            ST_SQR: begin
                w_mul_a = MUL_W'(r_m);
                w_mul_b = MUL_W'(r_m);
            end
            ST_LN2: begin
                w_mul_a = MUL_W'(w_l2);
                w_mul_b = LN2_Q32;
            end
            ST_TERM: begin
                w_mul_a = MUL_W'(r_y);
                w_mul_b = MUL_W'(w_nl);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;
    assign w_sq   = w_prod[2*PROB_W-1:PROB_W-1];
    assign w_l2   = {5'd16 - {1'b0, r_e}, 16'd0} - L2_W'(r_f);
    assign w_nl   = r_prod[NL_W+31:32] + NL_W'(r_prod[31]);
    assign w_term = r_prod[PROD_W-1:16] + (PROD_W-15)'(r_prod[15]);
    assign w_sum  = {1'b0, r_acc} + (ACC_W+1)'(w_term);

    assign w_div_start = (r_state == ST_FIN) && (r_count != '0);
    assign w_div_num   = {1'b0, r_acc} + NUM_W'(r_count[CNT_W-1:1]);

    cel_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_count),
        .o_res   (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_low  <= PROB_W'(1);
            r_clip_high <= {PROB_W{1'b1}};
            r_sparse    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CLIP_LOW:  r_clip_low  <= i_cfg_data;
                CFG_CLIP_HIGH: r_clip_high <= i_cfg_data;
                CFG_SPARSE:    r_sparse    <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= '0;
            r_count     <= '0;
            r_ovf_seen  <= 1'b0;
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            // A finished result moves to the output register once it is free,
            // and the batch state is cleared at that moment.
            if (r_res_pend && w_out_free) begin
                r_out_valid <= 1'b1;
                r_res_pend  <= 1'b0;
                r_acc       <= '0;
                r_count     <= '0;
                r_ovf_seen  <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_NORM;
                    end
                end
                ST_NORM: begin
                    r_step  <= '0;
                    r_state <= ST_SQR;
                end
                ST_SQR: begin
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(LOG_STEPS - 1)) begin
                        r_state <= ST_LN2;
                    end
                end
                ST_LN2: begin
                    r_state <= ST_TERM;
                end
                ST_TERM: begin
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (w_sum[ACC_W]) begin
                        r_acc      <= ACC_MAX;
                        r_ovf_seen <= 1'b1;
                    end else begin
                        r_acc <= w_sum[ACC_W-1:0];
                    end
                    if (r_los && (int'(r_count) < MAX_SAMPLES)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_state <= r_lob ? ST_FIN : ST_IDLE;
                end
                ST_FIN: begin
                    if (r_count == '0) begin
                        r_res_pend <= 1'b1;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_state <= ST_DWAIT;
                    end
                end
                ST_DWAIT: begin
                    if (w_div.done) begin
                        r_res_pend <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_c   <= w_c;
            r_y   <= w_y;
            r_los <= i_last_of_sample;
            r_lob <= i_last_of_batch;
        end
        case (r_state)
            ST_NORM: begin
                r_e <= w_e;
                r_m <= w_m_norm;
                r_f <= '0;
            end
            ST_SQR: begin
                // A square of two or more gives a one fraction bit and halves.
                r_f <= {r_f[PROB_W-2:0], w_sq[PROB_W]};
                r_m <= w_sq[PROB_W] ? w_sq[PROB_W:1] : w_sq[PROB_W-1:0];
            end
            ST_LN2, ST_TERM: begin
                r_prod <= w_prod[PROD_W-1:0];
            end
            ST_FIN: begin
                r_res_mean  <= '0;
                r_res_empty <= 1'b1;
                r_res_sat   <= r_ovf_seen;
            end
            ST_DWAIT: begin
                r_res_mean  <= w_div.ovf ? MEAN_MAX : w_div.quot;
                r_res_empty <= 1'b0;
                r_res_sat   <= r_ovf_seen || w_div.ovf;
            end
            default: ;
        endcase
        if (r_res_pend && w_out_free) begin
            r_out_mean  <= r_res_mean;
            r_out_empty <= r_res_empty;
            r_out_sat   <= r_res_sat;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_loss_mean   = r_out_mean;
    assign o_empty_batch = r_out_empty;
    assign o_saturated   = r_out_sat;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == ST_DWAIT)
        else $error("divider finished outside the wait state");

    a_rise_from_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_res_pend))
        else $error("output valid rose without a pending result");

    a_clear_on_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_pend && w_out_free |=> r_acc == '0 && r_count == '0 && !r_ovf_seen)
        else $error("batch state not cleared after result hand-off");

    a_empty_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_batch |-> o_loss_mean == '0)
        else $error("empty batch with a nonzero mean");

endmodule

FILE: hw/rtl/cel_div.sv
// Iterative restoring divider that forms the 24-bit batch mean and flags quotient overflow.
`timescale 1ns / 1ps

module cel_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cel_pkg::NUM_W-1:0]     i_num,
    input  logic [cel_pkg::CNT_W-1:0]     i_den,
    output cel_pkg::t_div_res             o_res
);
    import cel_pkg::*;

    localparam int QCNT_W = $clog2(MEAN_W + 1);
    localparam int HI_W   = NUM_W - MEAN_W;

    logic                r_busy;
    logic                r_done;
    logic                r_ovf;
    logic [QCNT_W-1:0]   r_cnt;
    logic [HI_W-1:0]     r_hi;
    logic [MEAN_W-1:0]   r_low;
    logic [CNT_W-1:0]    r_den;
    logic [CNT_W-1:0]    r_rem;

    logic [CNT_W:0]      w_trial;
    logic [CNT_W:0]      w_diff;
    logic                w_ge;

    assign w_trial = {r_rem, r_low[MEAN_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    // The quotient fits in 24 bits exactly when the upper part of the
    // numerator is below the divisor; that check comes before the quotient steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    if (r_hi >= HI_W'(r_den)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_done <= 1'b0;
                        r_cnt  <= QCNT_W'(1);
                    end
                end else if (r_cnt == QCNT_W'(MEAN_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                    r_cnt  <= r_cnt + QCNT_W'(1);
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi  <= i_num[NUM_W-1:MEAN_W];
            r_low <= i_num[MEAN_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_ovf <= r_hi >= HI_W'(r_den);
                r_rem <= r_hi[CNT_W-1:0];
            end else begin
                r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_low <= {r_low[MEAN_W-2:0], w_ge};
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_low;

endmodule
